// File: rtl/gql_pkg.sv
`timescale 1ns / 1ps
package gql_pkg;
    localparam logic [1:0] FUNC_GLYPH = 2'd0;
    localparam logic [1:0] FUNC_KERN  = 2'd1;
    localparam logic [1:0] FUNC_CHAR  = 2'd2;
    localparam logic [1:0] FUNC_END   = 2'd3;
    localparam logic [20:0] NEWLINE_CODE = 21'd10;
    localparam logic signed [23:0] POS_MAX = 24'sh7FFFFF;
    localparam logic signed [23:0] POS_MIN = -24'sh800000;
    localparam logic [15:0] LINE_LIMIT = 16'd65534;
    localparam logic [15:0] QUAD_LIMIT = 16'hFFFF;

    typedef struct packed {
        logic [14:0] gw;
        logic [14:0] gh;
        logic signed [15:0] bx;
        logic signed [15:0] by;
    } shape_t;

    typedef struct packed {
        logic [15:0] tx;
        logic [15:0] ty;
        logic [15:0] tw;
        logic [15:0] th;
    } texrect_t;

    function automatic logic signed [23:0] sat24(input logic signed [31:0] v);
        if (v > 32'(POS_MAX)) return POS_MAX;
        if (v < 32'(POS_MIN)) return POS_MIN;
        return v[23:0];
    endfunction
endpackage

// File: rtl/gql_ram.sv
`timescale 1ns / 1ps
module gql_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// File: rtl/gql_kern.sv
`timescale 1ns / 1ps
// kerning pair table in flops, associative match over all entries
module gql_kern #(
    parameter int KERN_PAIRS = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               load,
    input  logic [20:0]        first_code,
    input  logic [20:0]        second_code,
    input  logic [15:0]        amount,
    input  logic [20:0]        look_first,
    input  logic [20:0]        look_second,
    output logic               hit,
    output logic signed [15:0] hit_amount
);
    logic [20:0] first_reg  [KERN_PAIRS];
    logic [20:0] second_reg [KERN_PAIRS];
    logic [15:0] amount_reg [KERN_PAIRS];
    logic [KERN_PAIRS-1:0] valid_reg;
    logic [KERN_PAIRS-1:0] ld_match;
    logic [KERN_PAIRS-1:0] lk_match;
    logic [KERN_PAIRS-1:0] free_first;
    logic [KERN_PAIRS-1:0] wr_sel;

    always_comb
    begin
        for (int k = 0; k < KERN_PAIRS; k++)
        begin
            ld_match[k] = valid_reg[k] && first_reg[k] == first_code
                          && second_reg[k] == second_code;
            lk_match[k] = valid_reg[k] && first_reg[k] == look_first
                          && second_reg[k] == look_second;
        end
        // lowest free slot: isolate lowest zero of valid
        free_first = ~valid_reg & (valid_reg + KERN_PAIRS'(1));
        wr_sel = (|ld_match) ? ld_match : free_first;
        hit = |lk_match;
        hit_amount = '0;
        for (int k = 0; k < KERN_PAIRS; k++)
        begin
            hit_amount = hit_amount | (lk_match[k] ? amount_reg[k] : 16'd0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (load)
        begin
            valid_reg <= valid_reg | free_first & ~{KERN_PAIRS{|ld_match}};
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < KERN_PAIRS; k++)
        begin
            if (load && wr_sel[k])
            begin
                first_reg[k]  <= first_code;
                second_reg[k] <= second_code;
                amount_reg[k] <= amount;
            end
        end
    end
endmodule

// File: rtl/glyph_quad_layout_top.sv
`timescale 1ns / 1ps
// text layout engine: glyph and kerning loads, then characters, then an end item
// input channel: in_valid / in_stall with one port per field; output channel:
// out_valid / out_stall with one port per result field. baseline is written by
// cfg_we / cfg_data; the user must write it only while the block is idle, the block does not enforce it.
// a character item passes an input register, then a stage that reads the
// glyph memory (one registered read) and the kerning table, then a result stage
// that hands out four vertices one per transfer. the result stage takes a new
// item only once the last vertex of a found glyph has been transferred, so the
// single vertex output register limits the character rate. loads and missing
// glyphs produce no result; the end item yields one measurement transfer.
// reset clears the glyph and kerning valid bits, the pen state and all valid
// flags; the glyph memories hold stale data until loaded.
// when the receiver stalls, the result holds and the stall reaches the input
// once the internal stages are full.
module glyph_quad_layout_top #(
    parameter int GLYPH_CODES = 256,
    parameter int KERN_PAIRS  = 64,
    parameter int FRAC_BITS   = 12
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic signed [15:0] cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         func,
    input  logic [20:0]        code,
    input  logic [20:0]        second_code,
    input  logic [14:0]        glyph_width,
    input  logic [14:0]        glyph_height,
    input  logic signed [15:0] bearing_x,
    input  logic signed [15:0] bearing_y,
    input  logic signed [15:0] advance,
    input  logic [15:0]        tex_x,
    input  logic [15:0]        tex_y,
    input  logic [15:0]        tex_w,
    input  logic [15:0]        tex_h,
    output logic               out_valid,
    input  logic               out_stall,
    output logic               kind,
    output logic [1:0]         corner,
    output logic signed [23:0] pos_x,
    output logic signed [23:0] pos_y,
    output logic [16:0]        tex_u,
    output logic [16:0]        tex_v,
    output logic signed [23:0] text_width,
    output logic [15:0]        line_count,
    output logic [15:0]        quad_count,
    output logic               last
);
    import gql_pkg::*;

    localparam int GA = $clog2(GLYPH_CODES);
    localparam int GD = 1 << GA;

    logic signed [15:0] baseline_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) baseline_reg <= '0;
        else if (cfg_we) baseline_reg <= cfg_data;
    end

    // stage 1: input register
    logic s1_valid_reg;
    logic [1:0] s1_func_reg;
    logic [20:0] s1_code_reg, s1_code2_reg;
    shape_t s1_shape_reg;
    texrect_t s1_tex_reg;
    logic [15:0] s1_adv_reg;
    logic s2_ready, s1_ready;

    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_stall = !s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s1_valid_reg <= 1'b0;
        else if (s1_ready) s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_func_reg  <= func;
            s1_code_reg  <= code;
            s1_code2_reg <= second_code;
            s1_shape_reg <= '{glyph_width, glyph_height, bearing_x, bearing_y};
            s1_tex_reg   <= '{tex_x, tex_y, tex_w, tex_h};
            s1_adv_reg   <= advance;
        end
    end

    // glyph memory and valid bits; read issued from stage 1 as it advances
    logic s1_move, in_table;
    logic glyph_we;
    logic [GA-1:0] g_addr;
    logic [GA-1:0] r_addr;
    shape_t rd_shape;
    texrect_t rd_tex;
    logic [15:0] rd_adv;
    logic [GD-1:0] gvalid_reg;
    logic s2_gvalid_reg;

    assign s1_move  = s1_valid_reg && s2_ready;
    assign in_table = s1_code_reg < 21'(GLYPH_CODES);
    assign g_addr   = s1_code_reg[GA-1:0];
    assign glyph_we = s1_move && s1_func_reg == FUNC_GLYPH && in_table;

    gql_ram #(.WIDTH($bits(shape_t)), .DEPTH(GD)) u_shape (
        .clk(clk), .we(glyph_we), .waddr(g_addr), .wdata(s1_shape_reg),
        .raddr(r_addr), .rdata(rd_shape));
    gql_ram #(.WIDTH(64), .DEPTH(GD)) u_tex (
        .clk(clk), .we(glyph_we), .waddr(g_addr), .wdata(s1_tex_reg),
        .raddr(r_addr), .rdata(rd_tex));
    gql_ram #(.WIDTH(16), .DEPTH(GD)) u_adv (
        .clk(clk), .we(glyph_we), .waddr(g_addr), .wdata(s1_adv_reg),
        .raddr(r_addr), .rdata(rd_adv));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) gvalid_reg <= '0;
        else if (glyph_we) gvalid_reg[g_addr] <= 1'b1;
    end

    // stage 2: glyph data arrives; running state updated here
    logic s2_valid_reg;
    logic [1:0] s2_func_reg;
    logic [20:0] s2_code_reg;
    logic s3_ready;

    // a held stage 2 item keeps re-reading its own entry
    assign r_addr = s1_move ? g_addr : s2_code_reg[GA-1:0];

    assign s2_ready = !s2_valid_reg || s3_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) s2_valid_reg <= 1'b0;
        else if (s2_ready) s2_valid_reg <= s1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_func_reg   <= s1_func_reg;
            s2_code_reg   <= s1_code_reg;
            s2_gvalid_reg <= in_table && gvalid_reg[g_addr];
        end
    end

    logic signed [23:0] pen_reg, widest_reg;
    logic [15:0] line_reg, quads_reg;
    logic [20:0] prev_code_reg;
    logic prev_found_reg;
    logic khit;
    logic signed [15:0] kamt;

    gql_kern #(.KERN_PAIRS(KERN_PAIRS)) u_kern (
        .clk(clk), .rst_n(rst_n),
        .load(s1_move && s1_func_reg == FUNC_KERN),
        .first_code(s1_code_reg), .second_code(s1_code2_reg), .amount(s1_adv_reg),
        .look_first(prev_code_reg), .look_second(s2_code_reg),
        .hit(khit), .hit_amount(kamt));

    logic s2_move;
    logic signed [23:0] pen_k, pen_adv, widest_new, w_end;
    logic signed [31:0] left, right, top, bottom, ybase;
    logic is_char, is_nl, found;

    assign s2_move = s2_valid_reg && s3_ready;
    assign is_char = s2_func_reg == FUNC_CHAR;
    assign is_nl   = s2_code_reg == NEWLINE_CODE;
    assign found   = is_char && !is_nl && s2_gvalid_reg;

    always_comb
    begin
        pen_k = (prev_found_reg && khit)
                ? sat24(32'(pen_reg) + 32'(kamt)) : pen_reg;
        pen_adv = sat24(32'(pen_k) + 32'(signed'(rd_adv)));
        widest_new = (pen_k > widest_reg) ? pen_k : widest_reg;
        w_end = (pen_reg > widest_reg) ? pen_reg : widest_reg;
        ybase = -(32'(line_reg) <<< FRAC_BITS);
        left = 32'(pen_k) + 32'(rd_shape.bx);
        right = left + 32'(rd_shape.gw);
        top = ybase - 32'(rd_shape.by) + 32'(baseline_reg);
        bottom = top - 32'(rd_shape.gh);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pen_reg <= '0;
            widest_reg <= '0;
            line_reg <= '0;
            quads_reg <= '0;
            prev_code_reg <= '0;
            prev_found_reg <= 1'b0;
        end
        else if (s2_move && s2_func_reg == FUNC_END)
        begin
            pen_reg <= '0;
            widest_reg <= '0;
            line_reg <= '0;
            quads_reg <= '0;
            prev_code_reg <= '0;
            prev_found_reg <= 1'b0;
        end
        else if (s2_move && is_char)
        begin
            if (is_nl)
            begin
                widest_reg <= widest_new;
                pen_reg <= '0;
                if (line_reg < LINE_LIMIT) line_reg <= line_reg + 16'd1;
                prev_found_reg <= 1'b0;
            end
            else if (found)
            begin
                pen_reg <= pen_adv;
                if (quads_reg != QUAD_LIMIT) quads_reg <= quads_reg + 16'd1;
                prev_code_reg <= s2_code_reg;
                prev_found_reg <= 1'b1;
            end
            else
            begin
                pen_reg <= pen_k;
                prev_found_reg <= 1'b0;
            end
        end
    end

    // stage 3: result register, vertices sent one per transfer
    logic s3_valid_reg;
    logic s3_kind_reg;
    logic [1:0] s3_corner_reg;
    logic signed [23:0] s3_l_reg, s3_r_reg, s3_t_reg, s3_b_reg;
    logic [16:0] s3_u0_reg, s3_u1_reg, s3_v0_reg, s3_v1_reg;
    logic signed [23:0] s3_w_reg;
    logic [15:0] s3_lines_reg, s3_quads_reg;
    logic s3_done;

    assign s3_done  = !out_stall && (s3_kind_reg || s3_corner_reg == 2'd3);
    assign s3_ready = !s3_valid_reg || s3_done;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s3_valid_reg  <= 1'b0;
            s3_corner_reg <= '0;
        end
        else if (s3_ready)
        begin
            s3_valid_reg  <= s2_valid_reg && (found || s2_func_reg == FUNC_END);
            s3_corner_reg <= '0;
        end
        else if (!out_stall)
        begin
            s3_corner_reg <= s3_corner_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            s3_kind_reg  <= s2_func_reg == FUNC_END;
            s3_l_reg     <= sat24(left);
            s3_r_reg     <= sat24(right);
            s3_t_reg     <= sat24(top);
            s3_b_reg     <= sat24(bottom);
            s3_u0_reg    <= {1'b0, rd_tex.tx};
            s3_v0_reg    <= {1'b0, rd_tex.ty};
            s3_u1_reg    <= 17'(rd_tex.tx) + 17'(rd_tex.tw);
            s3_v1_reg    <= 17'(rd_tex.ty) + 17'(rd_tex.th);
            s3_w_reg     <= w_end;
            s3_lines_reg <= line_reg + 16'd1;
            s3_quads_reg <= quads_reg;
        end
    end

    assign out_valid = s3_valid_reg;

    always_comb
    begin
        kind = s3_kind_reg;
        corner = '0;
        pos_x = '0;
        pos_y = '0;
        tex_u = '0;
        tex_v = '0;
        text_width = '0;
        line_count = '0;
        quad_count = '0;
        last = 1'b1;
        if (s3_kind_reg)
        begin
            text_width = s3_w_reg;
            line_count = s3_lines_reg;
            quad_count = s3_quads_reg;
        end
        else
        begin
            corner = s3_corner_reg;
            last = s3_corner_reg == 2'd3;
            case (s3_corner_reg)
                2'd0:
                begin
                    pos_x = s3_l_reg; pos_y = s3_b_reg; tex_u = s3_u0_reg; tex_v = s3_v1_reg;
                end
                2'd1:
                begin
                    pos_x = s3_l_reg; pos_y = s3_t_reg; tex_u = s3_u0_reg; tex_v = s3_v0_reg;
                end
                2'd2:
                begin
                    pos_x = s3_r_reg; pos_y = s3_t_reg; tex_u = s3_u1_reg; tex_v = s3_v0_reg;
                end
                default:
                begin
                    pos_x = s3_r_reg; pos_y = s3_b_reg; tex_u = s3_u1_reg; tex_v = s3_v1_reg;
                end
            endcase
        end
    end
endmodule

// File: sim/tb.sv
`timescale 1ns / 1ps
module tb;
    import gql_pkg::*;

    localparam int NUM_CODES = 256;
    localparam int NUM_PAIRS = 64;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic [1:0]  func;
        logic [20:0] code;
        logic [20:0] second_code;
        logic [14:0] gw;
        logic [14:0] gh;
        logic [15:0] bx;
        logic [15:0] by;
        logic [15:0] adv;
        logic [15:0] tx;
        logic [15:0] ty;
        logic [15:0] tw;
        logic [15:0] th;
    } text_item_t;

    typedef struct {
        logic        kind;
        logic [1:0]  corner;
        logic [23:0] pos_x;
        logic [23:0] pos_y;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [23:0] text_width;
        logic [15:0] line_count;
        logic [15:0] quad_count;
        logic        last;
    } vertex_t;

    class layout_scoreboard;
        text_item_t glyphs[NUM_CODES];
        bit         glyph_ok[NUM_CODES];
        logic [20:0] kfirst[NUM_PAIRS];
        logic [20:0] ksecond[NUM_PAIRS];
        logic [15:0] kamount[NUM_PAIRS];
        bit          kern_ok[NUM_PAIRS];
        longint      pen;
        longint      line_idx;
        longint      widest;
        logic [20:0] prev_code;
        bit          prev_found;
        longint      quads;
        logic [15:0] baseline;
        vertex_t     pending_vertices[$];
        int          errors;

        function new();
            for (int i = 0; i < NUM_CODES; i++) glyph_ok[i] = 0;
            for (int i = 0; i < NUM_PAIRS; i++) kern_ok[i] = 0;
            pen = 0;
            line_idx = 0;
            widest = 0;
            prev_code = 0;
            prev_found = 0;
            quads = 0;
            baseline = 0;
            errors = 0;
        endfunction

        function longint clamp24(longint v);
            if (v > 8388607) return 8388607;
            if (v < -8388608) return -8388608;
            return v;
        endfunction

        function void push_vertex(logic [1:0] c, longint x, longint y, longint u, longint v);
            vertex_t r;
            r = '{default: '0};
            r.corner = c;
            r.pos_x = 24'(clamp24(x));
            r.pos_y = 24'(clamp24(y));
            r.tex_u = 17'(u);
            r.tex_v = 17'(v);
            r.last = (c == 2'd3);
            pending_vertices.insert(pending_vertices.size(), r);
        endfunction

        function void note_input(text_item_t it);
            text_item_t g;
            longint left, right, top, bottom, u0, u1, v0, v1;
            vertex_t m;
            bit placed;
            case (it.func)
                FUNC_GLYPH: if (it.code < NUM_CODES)
                begin
                    glyphs[it.code] = it;
                    glyph_ok[it.code] = 1;
                end
                FUNC_KERN:
                begin
                    placed = 0;
                    for (int k = 0; k < NUM_PAIRS && !placed; k++)
                        if (kern_ok[k] && kfirst[k] == it.code && ksecond[k] == it.second_code)
                        begin
                            kamount[k] = it.adv;
                            placed = 1;
                        end
                    // a new pair is dropped once the table is full
                    for (int k = 0; k < NUM_PAIRS && !placed; k++)
                        if (!kern_ok[k])
                        begin
                            kern_ok[k] = 1;
                            kfirst[k] = it.code;
                            ksecond[k] = it.second_code;
                            kamount[k] = it.adv;
                            placed = 1;
                        end
                end
                FUNC_CHAR:
                begin
                    if (prev_found)
                        for (int k = 0; k < NUM_PAIRS; k++)
                            if (kern_ok[k] && kfirst[k] == prev_code && ksecond[k] == it.code)
                            begin
                                pen = clamp24(pen + longint'($signed(kamount[k])));
                                break;
                            end
                    if (it.code == NEWLINE_CODE)
                    begin
                        if (pen > widest) widest = pen;
                        pen = 0;
                        if (line_idx < 65534) line_idx++;
                        prev_found = 0;
                    end
                    else if (it.code >= NUM_CODES || !glyph_ok[it.code])
                        prev_found = 0;
                    else
                    begin
                        g = glyphs[it.code];
                        left = pen + longint'($signed(g.bx));
                        right = left + longint'(g.gw);
                        top = -(line_idx * 4096) - longint'($signed(g.by))
                              + longint'($signed(baseline));
                        bottom = top - longint'(g.gh);
                        u0 = g.tx;
                        v0 = g.ty;
                        u1 = u0 + g.tw;
                        v1 = v0 + g.th;
                        push_vertex(2'd0, left, bottom, u0, v1);
                        push_vertex(2'd1, left, top, u0, v0);
                        push_vertex(2'd2, right, top, u1, v0);
                        push_vertex(2'd3, right, bottom, u1, v1);
                        pen = clamp24(pen + longint'($signed(g.adv)));
                        if (quads < 65535) quads++;
                        prev_code = it.code;
                        prev_found = 1;
                    end
                end
                default:
                begin
                    m = '{default: '0};
                    m.kind = 1;
                    m.text_width = 24'((pen > widest) ? pen : widest);
                    m.line_count = 16'(line_idx + 1);
                    m.quad_count = 16'(quads);
                    m.last = 1;
                    pending_vertices.insert(pending_vertices.size(), m);
                    pen = 0;
                    line_idx = 0;
                    widest = 0;
                    prev_code = 0;
                    prev_found = 0;
                    quads = 0;
                end
            endcase
        endfunction

        function void check_result(vertex_t got);
            vertex_t exp_r;
            if (pending_vertices.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d corner=%0d", $realtime,
                         got.kind, got.corner);
                errors++;
                return;
            end
            exp_r = pending_vertices.pop_front();
            if (got.kind !== exp_r.kind || got.corner !== exp_r.corner ||
                got.pos_x !== exp_r.pos_x || got.pos_y !== exp_r.pos_y ||
                got.tex_u !== exp_r.tex_u || got.tex_v !== exp_r.tex_v ||
                got.text_width !== exp_r.text_width || got.line_count !== exp_r.line_count ||
                got.quad_count !== exp_r.quad_count || got.last !== exp_r.last)
            begin
                $write("%0t: mismatch expected kind=%0d corner=%0d x=%h y=%h u=%h v=%h",
                       $realtime, exp_r.kind, exp_r.corner, exp_r.pos_x, exp_r.pos_y,
                       exp_r.tex_u, exp_r.tex_v);
                $display(" w=%h lines=%0d quads=%0d last=%0d",
                         exp_r.text_width, exp_r.line_count, exp_r.quad_count,
                         exp_r.last);
                $write("%0t:          actual   kind=%0d corner=%0d x=%h y=%h u=%h v=%h",
                       $realtime, got.kind, got.corner, got.pos_x, got.pos_y,
                       got.tex_u, got.tex_v);
                $display(" w=%h lines=%0d quads=%0d last=%0d",
                         got.text_width, got.line_count, got.quad_count, got.last);
                errors++;
            end
        endfunction
    endclass

    logic clk = 0;
    logic rst_n = 0;
    logic cfg_we = 0;
    logic signed [15:0] cfg_data = '0;
    logic in_valid = 0;
    logic in_stall;
    logic [1:0] func = '0;
    logic [20:0] code = '0;
    logic [20:0] second_code = '0;
    logic [14:0] glyph_width = '0;
    logic [14:0] glyph_height = '0;
    logic signed [15:0] bearing_x = '0;
    logic signed [15:0] bearing_y = '0;
    logic signed [15:0] advance = '0;
    logic [15:0] tex_x = '0;
    logic [15:0] tex_y = '0;
    logic [15:0] tex_w = '0;
    logic [15:0] tex_h = '0;
    logic out_valid;
    logic out_stall = 0;
    logic kind;
    logic [1:0] corner;
    logic signed [23:0] pos_x;
    logic signed [23:0] pos_y;
    logic [16:0] tex_u;
    logic [16:0] tex_v;
    logic signed [23:0] text_width;
    logic [15:0] line_count;
    logic [15:0] quad_count;
    logic last;

    int idle_pct = 0;
    int stall_pct = 0;
    int cycles = 0;
    layout_scoreboard sb = new();

    glyph_quad_layout_top u_top (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .func(func), .code(code),
        .second_code(second_code), .glyph_width(glyph_width),
        .glyph_height(glyph_height), .bearing_x(bearing_x), .bearing_y(bearing_y),
        .advance(advance), .tex_x(tex_x), .tex_y(tex_y), .tex_w(tex_w), .tex_h(tex_h),
        .out_valid(out_valid), .out_stall(out_stall), .kind(kind), .corner(corner),
        .pos_x(pos_x), .pos_y(pos_y), .tex_u(tex_u), .tex_v(tex_v),
        .text_width(text_width), .line_count(line_count), .quad_count(quad_count),
        .last(last)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // result transfer
    always @(posedge clk)
        if (rst_n && out_valid && !out_stall)
            sb.check_result('{kind, corner, pos_x, pos_y, tex_u, tex_v,
                              text_width, line_count, quad_count, last});

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    function automatic text_item_t noise_item(logic [1:0] f);
        text_item_t it;
        it.func = f;
        it.code = 21'($urandom_range(1114111));
        it.second_code = 21'($urandom_range(1114111));
        it.gw = 15'($urandom);
        it.gh = 15'($urandom);
        it.bx = 16'($urandom);
        it.by = 16'($urandom);
        it.adv = 16'($urandom);
        it.tx = 16'($urandom);
        it.ty = 16'($urandom);
        it.tw = 16'($urandom);
        it.th = 16'($urandom);
        return it;
    endfunction

    // mostly a small code pool so that kerning pairs get hit
    function automatic logic [20:0] pick_code();
        int r;
        r = $urandom_range(99);
        if (r < 70) return 21'(32 + $urandom_range(15));
        if (r < 82) return NEWLINE_CODE;
        if (r < 92) return 21'($urandom_range(NUM_CODES - 1));
        return 21'($urandom_range(1114111));
    endfunction

    function automatic text_item_t make_item(logic [1:0] f, logic [20:0] c);
        text_item_t it;
        it = noise_item(f);
        it.code = c;
        return it;
    endfunction

    // at a falling edge on entry and on return
    task automatic send_item(text_item_t it);
        while ($urandom_range(99) < idle_pct)
        begin
            in_valid <= 0;
            @(negedge clk);
        end
        func <= it.func;
        code <= it.code;
        second_code <= it.second_code;
        glyph_width <= it.gw;
        glyph_height <= it.gh;
        bearing_x <= it.bx;
        bearing_y <= it.by;
        advance <= it.adv;
        tex_x <= it.tx;
        tex_y <= it.ty;
        tex_w <= it.tw;
        tex_h <= it.th;
        in_valid <= 1;
        do @(posedge clk); while (in_stall);
        sb.note_input(it);
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending_vertices.size() != 0) @(negedge clk);
        repeat (10) @(negedge clk);
    endtask

    task automatic write_baseline(logic [15:0] v);
        drain();
        cfg_we <= 1;
        cfg_data <= v;
        @(negedge clk);
        cfg_we <= 0;
        sb.baseline = v;
    endtask

    task automatic send_char(logic [20:0] c);
        send_item(make_item(FUNC_CHAR, c));
    endtask

    task automatic random_phase(int n);
        text_item_t it;
        int r;
        int len;
        while (n > 0)
        begin
            r = $urandom_range(99);
            if (r < 15)
            begin
                it = noise_item(FUNC_GLYPH);
                if ($urandom_range(9) != 0) it.code = 21'(pick_code());
                send_item(it);
                n--;
            end
            else if (r < 27)
            begin
                it = noise_item(FUNC_KERN);
                if ($urandom_range(9) != 0)
                begin
                    it.code = pick_code();
                    it.second_code = pick_code();
                end
                send_item(it);
                n--;
            end
            else if (r < 32)
            begin
                send_item(noise_item($urandom_range(1) ? FUNC_CHAR : FUNC_END));
                n--;
            end
            else
            begin
                len = $urandom_range(1, 10);
                repeat (len) send_char(pick_code());
                send_item(noise_item(FUNC_END));
                n -= len + 1;
            end
        end
    endtask

    initial
    begin
        text_item_t it;
        repeat (10) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // two glyphs: each field is at its top in one and at its bottom in the other
        it = '{FUNC_GLYPH, 21'd65, 21'd0, 15'h7FFF, 15'h0, 16'h8000, 16'h7FFF,
               16'h7FFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        send_item(it);
        it = '{FUNC_GLYPH, 21'd66, 21'h1FFFFF, 15'h0, 15'h7FFF, 16'h7FFF, 16'h8000,
               16'h8000, 16'h0, 16'h0, 16'h0, 16'h0};
        send_item(it);
        send_item(make_item(FUNC_GLYPH, 21'd255));
        send_item(make_item(FUNC_GLYPH, 21'd300));
        send_item(make_item(FUNC_GLYPH, 21'h1FFFFF));
        it = make_item(FUNC_KERN, 21'd65);
        it.second_code = 21'd66;
        it.adv = 16'h8000;
        send_item(it);
        it.adv = 16'h7FFF;
        send_item(it);
        it = make_item(FUNC_KERN, 21'd66);
        it.second_code = NEWLINE_CODE;
        send_item(it);
        send_item(make_item(FUNC_END, 21'd0));
        send_char(21'd65);
        send_char(21'd66);
        send_char(NEWLINE_CODE);
        send_char(21'd300);
        send_char(21'd67);
        send_char(21'd255);
        send_char(21'd65);
        send_item(make_item(FUNC_END, 21'd5));

        write_baseline(16'h7FFF);
        send_char(21'd65);
        send_char(21'd66);
        send_item(make_item(FUNC_END, 21'd0));

        // long line: big advance plus a self kerning drives the pen into saturation
        it = '{FUNC_GLYPH, 21'd70, 21'd0, 15'h7FFF, 15'h100, 16'h7FFF, 16'h0,
               16'h7FFF, 16'h1000, 16'h2000, 16'h800, 16'h800};
        send_item(it);
        it = make_item(FUNC_KERN, 21'd70);
        it.second_code = 21'd70;
        it.adv = 16'h7FFF;
        send_item(it);
        repeat (132) send_char(21'd70);
        send_item(noise_item(FUNC_END));

        write_baseline(16'h8000);
        random_phase(85);
        idle_pct = 63;
        write_baseline(16'($urandom));
        random_phase(85);
        idle_pct = 0;
        stall_pct = 63;
        write_baseline(16'h0);
        random_phase(85);
        idle_pct = 35;
        stall_pct = 35;
        write_baseline(16'($urandom));
        random_phase(85);

        drain();
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end
endmodule
